// File: hw/rtl/ccc_pkg.sv
// ---------------------------------------------------------------------------
// ccc_pkg: shared types and constants for the calendar clock counter
// timestamp layout, operation codes and month length lookup
// ---------------------------------------------------------------------------
package ccc_pkg;

  localparam int unsigned SecW   = 6;
  localparam int unsigned MinW   = 6;
  localparam int unsigned HourW  = 5;
  localparam int unsigned DayW   = 5;
  localparam int unsigned MonthW = 4;
  localparam int unsigned YearW  = 16;
  localparam int unsigned OpW    = 2;

  // packed words on the stream, padded to whole bytes
  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 48;

  localparam logic [SecW-1:0]   SecLast   = SecW'(59);
  localparam logic [MinW-1:0]   MinLast   = MinW'(59);
  localparam logic [HourW-1:0]  HourLast  = HourW'(23);
  localparam logic [MonthW-1:0] MonthLast = MonthW'(12);
  localparam logic [YearW-1:0]  ResetYear = YearW'(2024);

  localparam logic [DayW-1:0] DaysShort = DayW'(28);
  localparam logic [DayW-1:0] Days30    = DayW'(30);
  localparam logic [DayW-1:0] Days31    = DayW'(31);

  typedef enum logic [OpW-1:0] {
    OP_TICK    = 2'd0,
    OP_LOAD    = 2'd1,
    OP_COMPARE = 2'd2,
    OP_NONE    = 2'd3
  } ccc_op_e;

  // year in the top bits so a plain unsigned compare gives calendar order
  typedef struct packed {
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
    logic [HourW-1:0]  hour;
    logic [MinW-1:0]   min;
    logic [SecW-1:0]   sec;
  } stamp_t;

  localparam stamp_t StampReset = '{
    year:  ResetYear,
    month: MonthW'(1),
    day:   DayW'(1),
    hour:  '0,
    min:   '0,
    sec:   '0
  };

  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m);
    logic [DayW-1:0] len;
    len = Days31;
    if (m == MonthW'(2)) begin
      len = DaysShort;
    end else if (m == MonthW'(4) || m == MonthW'(6) || m == MonthW'(9) ||
                 m == MonthW'(11)) begin
      len = Days30;
    end
    return len;
  endfunction

endpackage

// File: hw/rtl/ccc_clamp.sv
// ---------------------------------------------------------------------------
// ccc_clamp: field sanitiser for load and compare timestamps
// out-of-range fields are replaced by the first legal value
// ---------------------------------------------------------------------------
module ccc_clamp import ccc_pkg::*; (
  input  stamp_t raw_i,
  output stamp_t clamped_o
);

  logic [MonthW-1:0] month;

  always_comb begin
    month = raw_i.month;
    if (month == '0 || month > MonthLast) begin
      month = MonthW'(1);
    end
    clamped_o       = raw_i;
    clamped_o.month = month;
    if (raw_i.day == '0 || raw_i.day > month_len(month)) begin
      clamped_o.day = DayW'(1);
    end
    if (raw_i.sec > SecLast) begin
      clamped_o.sec = '0;
    end
    if (raw_i.min > MinLast) begin
      clamped_o.min = '0;
    end
    if (raw_i.hour > HourLast) begin
      clamped_o.hour = '0;
    end
  end

endmodule

// File: hw/rtl/ccc_core.sv
// ---------------------------------------------------------------------------
// ccc_core: timestamp register with tick, load and compare logic
// state moves on each advance; the updated time and flag are presented
// ---------------------------------------------------------------------------
module ccc_core import ccc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    advance_i,
  input  ccc_op_e op_i,
  input  stamp_t  given_i,
  output stamp_t  now_next_o,
  output logic    earlier_o
);

  stamp_t now_q, now_d;
  stamp_t given_clamped;
  stamp_t ticked;

  ccc_clamp u_clamp (
    .raw_i     (given_i),
    .clamped_o (given_clamped)
  );

  // cascaded carry through second, minute, hour, day, month and year
  always_comb begin
    ticked = now_q;
    if (now_q.sec >= SecLast) begin
      ticked.sec = '0;
      if (now_q.min >= MinLast) begin
        ticked.min = '0;
        if (now_q.hour >= HourLast) begin
          ticked.hour = '0;
          if (now_q.day >= month_len(now_q.month)) begin
            ticked.day = DayW'(1);
            if (now_q.month >= MonthLast) begin
              ticked.month = MonthW'(1);
              ticked.year  = now_q.year + YearW'(1);
            end else begin
              ticked.month = now_q.month + MonthW'(1);
            end
          end else begin
            ticked.day = now_q.day + DayW'(1);
          end
        end else begin
          ticked.hour = now_q.hour + HourW'(1);
        end
      end else begin
        ticked.min = now_q.min + MinW'(1);
      end
    end else begin
      ticked.sec = now_q.sec + SecW'(1);
    end
  end

  always_comb begin
    now_d     = now_q;
    earlier_o = 1'b0;
    unique case (op_i)
      OP_TICK:    now_d = ticked;
      OP_LOAD:    now_d = given_clamped;
      OP_COMPARE: earlier_o = (now_q < given_clamped);
      OP_NONE:    now_d = now_q;
      default:    now_d = now_q;
    endcase
  end

  assign now_next_o = now_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q <= StampReset;
    end else if (advance_i) begin
      now_q <= now_d;
    end
  end

endmodule

// File: hw/rtl/calendar_clock_counter.sv
// an accepted word passes through the input register, then the result register, before its result is on the stream
// throughput: one word per cycle, limited only by the result stream's tready
// the input register refills in the same cycle that it hands over to the core
// reset: asynchronous, active low; time returns to 00:00:00 on 1 january 2024
// and both stages are emptied
// ---------------------------------------------------------------------------
// calendar_clock_counter: second-resolution clock with calendar
// tick, load and compare words on a stream in, one result word out per word
// ---------------------------------------------------------------------------
module calendar_clock_counter import ccc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // sec[5:0] min[11:6] hour[16:12] day[21:17] month[25:22] year[41:26], zero pad
  input  logic [InDataW-1:0]  s_axis_tdata,
  // op[1:0]
  input  logic [OpW-1:0]      s_axis_tuser,
  // result stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // sec[5:0] min[11:6] hour[16:12] day[21:17] month[25:22] year[41:26]
  // earlier[42], zero pad
  output logic [OutDataW-1:0] m_axis_tdata
);

  localparam int unsigned StampW = $bits(stamp_t);

  // input register: holds one accepted word until the core consumes it
  logic    in_valid_q;
  ccc_op_e in_op_q;
  stamp_t  in_stamp_q;

  // result register: decouples the core from result back-pressure
  logic    out_valid_q;
  stamp_t  out_stamp_q;
  logic    out_earlier_q;

  logic    advance;
  stamp_t  now_next;
  logic    earlier;
  stamp_t  in_stamp_d;

  // the core moves a word when the result register is free or being drained
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  // unpack the incoming word, sec in the lowest bits
  assign in_stamp_d = '{
    sec:   s_axis_tdata[5:0],
    min:   s_axis_tdata[11:6],
    hour:  s_axis_tdata[16:12],
    day:   s_axis_tdata[21:17],
    month: s_axis_tdata[25:22],
    year:  s_axis_tdata[41:26]
  };

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  // payload only, no reset
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_op_q    <= ccc_op_e'(s_axis_tuser);
      in_stamp_q <= in_stamp_d;
    end
  end

  ccc_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .advance_i  (advance),
    .op_i       (in_op_q),
    .given_i    (in_stamp_q),
    .now_next_o (now_next),
    .earlier_o  (earlier)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_stamp_q   <= now_next;
      out_earlier_q <= earlier;
    end
  end

  // repack with the same field order as the input word
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {
    (OutDataW - StampW - 1)'(0),
    out_earlier_q,
    out_stamp_q.year,
    out_stamp_q.month,
    out_stamp_q.day,
    out_stamp_q.hour,
    out_stamp_q.min,
    out_stamp_q.sec
  };

endmodule

// File: hw/rtl/ccc_checker.sv
// ---------------------------------------------------------------------------
// ccc_checker: port-level checks for the calendar clock counter
// bound to the top level, watches both streams over time
// ---------------------------------------------------------------------------
module ccc_checker import ccc_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata
);

  // a pending result word stays until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result word dropped before acceptance");

  // input only stalls behind a waiting result word
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without result back-pressure");

  // every reported time has legal second, minute, hour and month fields and a nonzero day
  a_fields_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[5:0] <= 6'd59 && m_axis_tdata[11:6] <= 6'd59 &&
      m_axis_tdata[16:12] <= 5'd23 && m_axis_tdata[21:17] != 5'd0 &&
      m_axis_tdata[25:22] != 4'd0 && m_axis_tdata[25:22] <= 4'd12)
    else $error("result word holds an illegal time");

  // padding above the flag is zero
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[OutDataW-1:43] == '0)
    else $error("result padding not zero");

endmodule

bind calendar_clock_counter ccc_checker u_ccc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
